### rtl/delta_list_sleep_queue_core_defines.svh
// Assertion macros for the sleep queue RTL.
// They expand to nothing when SYNTHESIS is defined.
`ifndef DELTA_LIST_SLEEP_QUEUE_CORE_DEFINES_SVH
`define DELTA_LIST_SLEEP_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every edge outside reset.
`define DLSQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, during reset too.
`define DLSQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define DLSQ_ASSERT(lbl, prop, msg)
`define DLSQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/dlsq_pkg.sv
package dlsq_pkg;

    // Queue depth and derived widths.
    localparam int DEPTH   = 16;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW      = $clog2(DEPTH + 1);
    localparam int ID_W    = 16;
    localparam int DELTA_W = 32;
    localparam int OCC_W   = 5;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_POP    = 2'd2,
        OP_LOOKUP = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK_RD,
        S_WALK_CHK,
        S_SHUP_RD,
        S_SHUP_WR,
        S_PLACE,
        S_ADJ,
        S_SHDN_RD,
        S_SHDN_WR,
        S_FIN,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    start;
        logic    rd;
        rd_sel_t rd_sel;
        logic    walk_adv;
        logic    idx_inc;
        logic    hit_save;
        logic    shup_wr;
        logic    place;
        logic    adj_wr;
        logic    shdn_wr;
        logic    fill_dec;
        logic    fin;
        status_t status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic idx_at_fill;
        logic idx_at_pos;
        logic walk_go;
        logic id_match;
        logic idx_lt_fill;
        logic next_lt_fill;
    } sts_t;

endpackage

### rtl/dlsq_datapath.sv
module dlsq_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dlsq_pkg::cmd_t              cmd,
    output dlsq_pkg::sts_t              sts,
    input  logic [1:0]                  s_op,
    input  logic [dlsq_pkg::ID_W-1:0]    s_thread_id,
    input  logic [dlsq_pkg::DELTA_W-1:0] s_wait_ticks,
    output logic [1:0]                  m_status,
    output logic [dlsq_pkg::ID_W-1:0]    m_out_id,
    output logic [dlsq_pkg::DELTA_W-1:0] m_out_delta,
    output logic [dlsq_pkg::OCC_W-1:0]   m_occupancy
);

    // Entry storage, one write and one registered read per cycle.
    logic [dlsq_pkg::ID_W-1:0]    mem_id    [dlsq_pkg::DEPTH];
    logic [dlsq_pkg::DELTA_W-1:0] mem_delta [dlsq_pkg::DEPTH];

    dlsq_pkg::op_t                op_reg;
    logic [dlsq_pkg::ID_W-1:0]    id_reg;
    logic [dlsq_pkg::DELTA_W-1:0] wait_reg;
    logic [dlsq_pkg::IW-1:0]      idx_reg, idx_next;
    logic [dlsq_pkg::IW-1:0]      pos_reg;
    logic [dlsq_pkg::IW-1:0]      fill_reg, fill_next;
    logic [dlsq_pkg::DELTA_W-1:0] before_reg;
    logic [dlsq_pkg::DELTA_W-1:0] carry_reg;
    logic [dlsq_pkg::ID_W-1:0]    hit_id_reg;
    logic [dlsq_pkg::DELTA_W-1:0] hit_delta_reg;
    logic [dlsq_pkg::ID_W-1:0]    rd_id_reg;
    logic [dlsq_pkg::DELTA_W-1:0] rd_delta_reg;

    logic [1:0]                   status_reg;
    logic [dlsq_pkg::ID_W-1:0]    out_id_reg;
    logic [dlsq_pkg::DELTA_W-1:0] out_delta_reg;
    logic [dlsq_pkg::OCC_W-1:0]   occ_reg;

    logic [dlsq_pkg::IW-1:0]      rd_idx;
    logic [dlsq_pkg::AW-1:0]      rd_addr;
    logic [dlsq_pkg::AW-1:0]      wr_addr;
    logic                         wr_en;
    logic [dlsq_pkg::ID_W-1:0]    wr_id;
    logic [dlsq_pkg::DELTA_W-1:0] wr_delta;
    logic [dlsq_pkg::DELTA_W-1:0] new_delta;
    logic [dlsq_pkg::DELTA_W:0]   walk_sum;
    logic [dlsq_pkg::IW:0]        idx_plus;
    logic                         give_entry;

    // New entry delta and the walk test on the running sum.
    assign new_delta = wait_reg - before_reg;
    assign walk_sum  = {1'b0, before_reg} + {1'b0, rd_delta_reg};
    assign idx_plus  = {1'b0, idx_reg} + 1'b1;

    // Read address selection.
    always_comb begin
        unique case (cmd.rd_sel)
            dlsq_pkg::RD_PREV: rd_idx = idx_reg - 1'b1;
            dlsq_pkg::RD_NEXT: rd_idx = idx_plus[dlsq_pkg::IW-1:0];
            default:           rd_idx = idx_reg;
        endcase
    end
    assign rd_addr = rd_idx[dlsq_pkg::AW-1:0];
    assign wr_addr = idx_reg[dlsq_pkg::AW-1:0];

    // Write data selection.
    always_comb begin
        wr_en    = cmd.shup_wr | cmd.place | cmd.adj_wr | cmd.shdn_wr;
        wr_id    = rd_id_reg;
        wr_delta = rd_delta_reg;
        priority if (cmd.place) begin
            wr_id    = id_reg;
            wr_delta = new_delta;
        end else if (cmd.adj_wr) begin
            wr_id    = hit_id_reg;
            wr_delta = hit_delta_reg - new_delta;
        end else if (cmd.shdn_wr) begin
            wr_delta = rd_delta_reg + carry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_id[wr_addr]    <= wr_id;
            mem_delta[wr_addr] <= wr_delta;
        end
        if (cmd.rd) begin
            rd_id_reg    <= mem_id[rd_addr];
            rd_delta_reg <= mem_delta[rd_addr];
        end
    end

    // Walk index.
    always_comb begin
        idx_next = idx_reg;
        priority if (cmd.start) begin
            idx_next = '0;
        end else if (cmd.hit_save && op_reg == dlsq_pkg::OP_INSERT) begin
            idx_next = fill_reg;
        end else if (cmd.walk_adv || cmd.idx_inc || cmd.place || cmd.shdn_wr) begin
            idx_next = idx_plus[dlsq_pkg::IW-1:0];
        end else if (cmd.shup_wr) begin
            idx_next = idx_reg - 1'b1;
        end
    end

    // Entry count.
    always_comb begin
        fill_next = fill_reg;
        priority if (cmd.place) begin
            fill_next = fill_reg + 1'b1;
        end else if (cmd.fill_dec) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Operation and walk registers.
    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd.start) begin
            op_reg     <= dlsq_pkg::op_t'(s_op);
            id_reg     <= s_thread_id;
            wait_reg   <= s_wait_ticks;
            before_reg <= '0;
        end
        if (cmd.walk_adv) begin
            before_reg <= walk_sum[dlsq_pkg::DELTA_W-1:0];
        end
        if (cmd.hit_save) begin
            pos_reg       <= idx_reg;
            hit_id_reg    <= rd_id_reg;
            hit_delta_reg <= rd_delta_reg;
            carry_reg     <= (op_reg == dlsq_pkg::OP_REMOVE) ? rd_delta_reg : '0;
        end else if (cmd.shdn_wr) begin
            carry_reg <= '0;
        end
    end

    // Result register.
    assign give_entry = (cmd.status == dlsq_pkg::ST_OK) &&
                        (op_reg == dlsq_pkg::OP_POP || op_reg == dlsq_pkg::OP_LOOKUP);

    always_ff @(posedge aclk) begin
        if (cmd.fin) begin
            status_reg    <= cmd.status;
            out_id_reg    <= give_entry ? hit_id_reg : '0;
            out_delta_reg <= give_entry ? hit_delta_reg : '0;
            occ_reg       <= dlsq_pkg::OCC_W'(fill_reg);
        end
    end

    assign m_status    = status_reg;
    assign m_out_id    = out_id_reg;
    assign m_out_delta = out_delta_reg;
    assign m_occupancy = occ_reg;

    // Status back to the controller.
    always_comb begin
        sts.op           = op_reg;
        sts.full         = (fill_reg == dlsq_pkg::IW'(dlsq_pkg::DEPTH));
        sts.empty        = (fill_reg == '0);
        sts.idx_at_fill  = (idx_reg == fill_reg);
        sts.idx_at_pos   = (idx_reg == pos_reg);
        sts.walk_go      = (walk_sum <= {1'b0, wait_reg});
        sts.id_match     = (rd_id_reg == id_reg);
        sts.idx_lt_fill  = (idx_reg < fill_reg);
        sts.next_lt_fill = (idx_plus < {1'b0, fill_reg});
    end

endmodule

### rtl/dlsq_ctrl.sv
module dlsq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  dlsq_pkg::sts_t sts,
    output dlsq_pkg::cmd_t cmd
);

    dlsq_pkg::state_t state_reg, state_next;
    dlsq_pkg::status_t fin_status_reg, fin_status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dlsq_pkg::S_IDLE;
            fin_status_reg <= dlsq_pkg::ST_OK;
        end else begin
            state_reg      <= state_next;
            fin_status_reg <= fin_status_next;
        end
    end

    // Next state.
    always_comb begin
        state_next      = state_reg;
        fin_status_next = fin_status_reg;
        unique case (state_reg)
            dlsq_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next      = dlsq_pkg::S_DECIDE;
                    fin_status_next = dlsq_pkg::ST_OK;
                end
            end
            dlsq_pkg::S_DECIDE: begin
                if (sts.op == dlsq_pkg::OP_INSERT && sts.full) begin
                    fin_status_next = dlsq_pkg::ST_FULL;
                    state_next      = dlsq_pkg::S_FIN;
                end else if (sts.op == dlsq_pkg::OP_POP && sts.empty) begin
                    fin_status_next = dlsq_pkg::ST_EMPTY;
                    state_next      = dlsq_pkg::S_FIN;
                end else begin
                    state_next = dlsq_pkg::S_WALK_RD;
                end
            end
            dlsq_pkg::S_WALK_RD: begin
                if (!sts.idx_at_fill) begin
                    state_next = dlsq_pkg::S_WALK_CHK;
                end else if (sts.op == dlsq_pkg::OP_INSERT) begin
                    state_next = dlsq_pkg::S_SHUP_RD;
                end else begin
                    fin_status_next = dlsq_pkg::ST_NOT_FOUND;
                    state_next      = dlsq_pkg::S_FIN;
                end
            end
            dlsq_pkg::S_WALK_CHK: begin
                unique case (sts.op)
                    dlsq_pkg::OP_INSERT:
                        state_next = sts.walk_go ? dlsq_pkg::S_WALK_RD : dlsq_pkg::S_SHUP_RD;
                    dlsq_pkg::OP_REMOVE:
                        state_next = sts.id_match ? dlsq_pkg::S_SHDN_RD : dlsq_pkg::S_WALK_RD;
                    dlsq_pkg::OP_POP:
                        state_next = dlsq_pkg::S_SHDN_RD;
                    default:
                        state_next = sts.id_match ? dlsq_pkg::S_FIN : dlsq_pkg::S_WALK_RD;
                endcase
            end
            dlsq_pkg::S_SHUP_RD: begin
                state_next = sts.idx_at_pos ? dlsq_pkg::S_PLACE : dlsq_pkg::S_SHUP_WR;
            end
            dlsq_pkg::S_SHUP_WR: state_next = dlsq_pkg::S_SHUP_RD;
            dlsq_pkg::S_PLACE:   state_next = dlsq_pkg::S_ADJ;
            dlsq_pkg::S_ADJ:     state_next = dlsq_pkg::S_FIN;
            dlsq_pkg::S_SHDN_RD: begin
                state_next = sts.next_lt_fill ? dlsq_pkg::S_SHDN_WR : dlsq_pkg::S_FIN;
            end
            dlsq_pkg::S_SHDN_WR: state_next = dlsq_pkg::S_SHDN_RD;
            dlsq_pkg::S_FIN:     state_next = dlsq_pkg::S_OUT;
            dlsq_pkg::S_OUT: begin
                if (m_ready) begin
                    state_next = dlsq_pkg::S_IDLE;
                end
            end
            default: state_next = dlsq_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath commands.
    always_comb begin
        cmd        = '0;
        cmd.rd_sel = dlsq_pkg::RD_IDX;
        cmd.status = fin_status_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            dlsq_pkg::S_IDLE: begin
                s_ready   = 1'b1;
                cmd.start = s_valid;
            end
            dlsq_pkg::S_WALK_RD: begin
                if (!sts.idx_at_fill) begin
                    cmd.rd = 1'b1;
                end else if (sts.op == dlsq_pkg::OP_INSERT) begin
                    cmd.hit_save = 1'b1;
                end
            end
            dlsq_pkg::S_WALK_CHK: begin
                unique case (sts.op)
                    dlsq_pkg::OP_INSERT: begin
                        cmd.walk_adv = sts.walk_go;
                        cmd.hit_save = !sts.walk_go;
                    end
                    dlsq_pkg::OP_POP: cmd.hit_save = 1'b1;
                    default: begin
                        cmd.hit_save = sts.id_match;
                        cmd.idx_inc  = !sts.id_match;
                    end
                endcase
            end
            dlsq_pkg::S_SHUP_RD: begin
                if (!sts.idx_at_pos) begin
                    cmd.rd     = 1'b1;
                    cmd.rd_sel = dlsq_pkg::RD_PREV;
                end
            end
            dlsq_pkg::S_SHUP_WR: cmd.shup_wr = 1'b1;
            dlsq_pkg::S_PLACE:   cmd.place   = 1'b1;
            dlsq_pkg::S_ADJ:     cmd.adj_wr  = sts.idx_lt_fill;
            dlsq_pkg::S_SHDN_RD: begin
                if (sts.next_lt_fill) begin
                    cmd.rd     = 1'b1;
                    cmd.rd_sel = dlsq_pkg::RD_NEXT;
                end else begin
                    cmd.fill_dec = 1'b1;
                end
            end
            dlsq_pkg::S_SHDN_WR: cmd.shdn_wr = 1'b1;
            dlsq_pkg::S_FIN:     cmd.fin     = 1'b1;
            dlsq_pkg::S_OUT:     m_valid     = 1'b1;
            default: ;
        endcase
    end

endmodule

### rtl/delta_list_sleep_queue_core.sv
// The core handles one item at a time; each stored entry visited takes a read and then a
// compare or copy step on the entry memory, and the next input beat can be taken in the cycle
// after the result beat is accepted.
// Reset (aresetn low, synchronous) empties the queue and returns the controller to idle;
// the entry memory keeps its contents and is never read past the entry count.
`include "delta_list_sleep_queue_core_defines.svh"

module delta_list_sleep_queue_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [dlsq_pkg::ID_W-1:0]    s_thread_id,
    input  logic [dlsq_pkg::DELTA_W-1:0] s_wait_ticks,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [dlsq_pkg::ID_W-1:0]    m_out_id,
    output logic [dlsq_pkg::DELTA_W-1:0] m_out_delta,
    output logic [dlsq_pkg::OCC_W-1:0]   m_occupancy
);

    dlsq_pkg::cmd_t cmd;
    dlsq_pkg::sts_t sts;

    // Sequencer.
    dlsq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Entry storage, walk arithmetic and result register.
    dlsq_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_op         (s_op),
        .s_thread_id  (s_thread_id),
        .s_wait_ticks (s_wait_ticks),
        .m_status     (m_status),
        .m_out_id     (m_out_id),
        .m_out_delta  (m_out_delta),
        .m_occupancy  (m_occupancy)
    );

    `DLSQ_ASSERT(a_no_overlap, !(s_ready && m_valid), "input taken while a beat is pending")
    `DLSQ_ASSERT(a_occ_range, m_valid |-> (m_occupancy <= dlsq_pkg::OCC_W'(dlsq_pkg::DEPTH)), "occupancy above depth")
    `DLSQ_ASSERT(a_fail_zero, (m_valid && m_status != dlsq_pkg::ST_OK) |-> (m_out_id == '0 && m_out_delta == '0), "failed beat carries data")
    `DLSQ_ASSERT(a_full_occ, (m_valid && m_status == dlsq_pkg::ST_FULL) |-> (m_occupancy == dlsq_pkg::OCC_W'(dlsq_pkg::DEPTH)), "full reported below depth")
    `DLSQ_ASSERT(a_empty_occ, (m_valid && m_status == dlsq_pkg::ST_EMPTY) |-> (m_occupancy == '0), "empty reported with entries")

endmodule
